// ===== hw/rtl/mpq_pkg.sv =====
// shared types, codes and field widths for the multilevel priority queue
package mpq_pkg;

    localparam int ID_FIELD_BITS    = 16;
    localparam int PRIO_BITS        = 4;
    localparam int COUNT_FIELD_BITS = 8;

    localparam int LEVELS_DEFAULT   = 8;
    localparam int DEPTH_DEFAULT    = 16;
    localparam int ID_BITS_DEFAULT  = 16;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_PRIO  = 2'd2,
        STATUS_EMPTY_POP = 2'd3
    } status_t;

    typedef struct packed {
        status_t                       status;
        logic                          head_valid;
        logic [ID_FIELD_BITS-1:0]      head_task_id;
        logic [PRIO_BITS-1:0]          head_priority;
        logic [ID_FIELD_BITS-1:0]      removed_task_id;
        logic [COUNT_FIELD_BITS-1:0]   total_count;
    } result_t;

endpackage

// ===== hw/rtl/mpq_in_if.sv =====
// request channel: push or pop word
interface mpq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [mpq_pkg::ID_FIELD_BITS-1:0]    task_id;
    logic [mpq_pkg::PRIO_BITS-1:0]        priority_req;

    modport source (output valid, output func, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input func, input task_id, input priority_req,
                    output ready);
endinterface

// ===== hw/rtl/mpq_out_if.sv =====
// response channel: status and head word after each request
interface mpq_out_if;
    logic                                  valid;
    logic                                  ready;
    mpq_pkg::status_t                      status;
    logic                                  head_valid;
    logic [mpq_pkg::ID_FIELD_BITS-1:0]     head_task_id;
    logic [mpq_pkg::PRIO_BITS-1:0]         head_priority;
    logic [mpq_pkg::ID_FIELD_BITS-1:0]     removed_task_id;
    logic [mpq_pkg::COUNT_FIELD_BITS-1:0]  total_count;

    modport source (output valid, output status, output head_valid, output head_task_id,
                    output head_priority, output removed_task_id, output total_count,
                    input ready);
    modport sink   (input valid, input status, input head_valid, input head_task_id,
                    input head_priority, input removed_task_id, input total_count,
                    output ready);
endinterface

// ===== hw/rtl/mpq_store.sv =====
// task memory: one write port, one read port, registered read data
module mpq_store #(
    parameter int WORDS     = mpq_pkg::LEVELS_DEFAULT * mpq_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = mpq_pkg::ID_BITS_DEFAULT,
    parameter int ADDR_BITS = $clog2(WORDS)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mpq_ctrl.sv =====
// per-level ring pointers, request sequencing and response register
module mpq_ctrl #(
    parameter int LEVELS    = mpq_pkg::LEVELS_DEFAULT,
    parameter int DEPTH     = mpq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS   = mpq_pkg::ID_BITS_DEFAULT,
    parameter int ADDR_BITS = $clog2(LEVELS * DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mpq_in_if.sink               req,
    mpq_out_if.source            rsp,
    output logic                 mem_wr_en,
    output logic [ADDR_BITS-1:0] mem_wr_addr,
    output logic [ID_BITS-1:0]   mem_wr_data,
    output logic [ADDR_BITS-1:0] mem_rd_addr,
    input  logic [ID_BITS-1:0]   mem_rd_data
);

    localparam int LB = $clog2(LEVELS);
    localparam int PB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);
    localparam int TB = $clog2(LEVELS * DEPTH + 1);
    localparam int IDW = mpq_pkg::ID_FIELD_BITS;
    localparam int PW = mpq_pkg::PRIO_BITS;
    localparam int CW = mpq_pkg::COUNT_FIELD_BITS;
    localparam logic [ADDR_BITS-1:0] DEPTH_A = ADDR_BITS'(DEPTH);
    localparam logic [PB-1:0] LAST_PTR = PB'(DEPTH - 1);
    localparam logic [CB-1:0] FULL_CNT = CB'(DEPTH);
    localparam logic [PW:0] LEVELS_P = (PW + 1)'(LEVELS);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t               state_reg;
    logic [PB-1:0]        head_reg [LEVELS];
    logic [PB-1:0]        tail_reg [LEVELS];
    logic [CB-1:0]        count_reg [LEVELS];
    logic [TB-1:0]        total_reg;
    logic [ID_BITS-1:0]   head_task_reg;
    mpq_pkg::status_t     status_reg;
    logic [ID_BITS-1:0]   removed_reg;
    logic                 any_reg;
    logic [LB-1:0]        top_reg;
    logic                 fwd_reg;
    logic [ID_BITS-1:0]   fwd_id_reg;
    logic                 out_valid_reg;
    mpq_pkg::result_t     out_reg;

    logic [PB-1:0]        head_next [LEVELS];
    logic [PB-1:0]        tail_next [LEVELS];
    logic [CB-1:0]        count_next [LEVELS];
    logic [TB-1:0]        total_next;

    logic                 accept;
    logic [ID_BITS-1:0]   id_in;
    logic [ID_BITS+IDW-1:0] id_wide;
    logic [PW-1:0]        prio_m1;
    logic                 prio_ok;
    logic                 cur_any;
    logic [LB-1:0]        cur_top;
    logic                 new_any;
    logic [LB-1:0]        new_top;
    logic [LB-1:0]        lv;
    logic                 push_ok;
    logic                 pop_ok;
    mpq_pkg::status_t     status_c;
    logic [ID_BITS-1:0]   head_word;
    logic [ID_BITS+IDW-1:0] head_wide;
    logic [ID_BITS+IDW-1:0] removed_wide;
    logic [TB+CW-1:0]     total_wide;
    logic [LB:0]          prio_out;
    logic [LB+PW:0]       prio_wide;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign id_wide = (ID_BITS + IDW)'(req.task_id);
    assign id_in   = id_wide[ID_BITS-1:0];
    assign prio_m1 = req.priority_req - PW'(1);
    assign prio_ok = (req.priority_req != '0) && ({1'b0, req.priority_req} <= LEVELS_P);

    // highest non-empty level before the request
    always_comb
    begin
        cur_any = 1'b0;
        cur_top = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (count_reg[l] != '0)
            begin
                cur_any = 1'b1;
                cur_top = LB'(l);
            end
        end
    end

    always_comb
    begin
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        status_c = mpq_pkg::STATUS_OK;
        lv       = cur_top;
        if (req.func == mpq_pkg::FUNC_PUSH)
        begin
            lv = prio_m1[LB-1:0];
            if (!prio_ok)
            begin
                status_c = mpq_pkg::STATUS_BAD_PRIO;
            end
            else if (count_reg[lv] == FULL_CNT)
            begin
                status_c = mpq_pkg::STATUS_FULL;
            end
            else
            begin
                push_ok = 1'b1;
            end
        end
        else
        begin
            if (!cur_any)
            begin
                status_c = mpq_pkg::STATUS_EMPTY_POP;
            end
            else
            begin
                pop_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
        end
        total_next = total_reg;
        if (accept && push_ok)
        begin
            tail_next[lv]  = (tail_reg[lv] == LAST_PTR) ? '0 : tail_reg[lv] + PB'(1);
            count_next[lv] = count_reg[lv] + CB'(1);
            total_next     = total_reg + TB'(1);
        end
        else if (accept && pop_ok)
        begin
            head_next[lv]  = (head_reg[lv] == LAST_PTR) ? '0 : head_reg[lv] + PB'(1);
            count_next[lv] = count_reg[lv] - CB'(1);
            total_next     = total_reg - TB'(1);
        end
    end

    // highest non-empty level after the request
    always_comb
    begin
        new_any = 1'b0;
        new_top = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (count_next[l] != '0)
            begin
                new_any = 1'b1;
                new_top = LB'(l);
            end
        end
    end

    assign mem_wr_en   = accept && push_ok;
    assign mem_wr_addr = ADDR_BITS'(lv) * DEPTH_A + ADDR_BITS'(tail_reg[lv]);
    assign mem_wr_data = id_in;
    assign mem_rd_addr = ADDR_BITS'(new_top) * DEPTH_A + ADDR_BITS'(head_next[new_top]);

    // a push into an empty level that becomes the top collides with the read
    assign head_word    = fwd_reg ? fwd_id_reg : mem_rd_data;
    assign head_wide    = (ID_BITS + IDW)'(head_word);
    assign removed_wide = (ID_BITS + IDW)'(removed_reg);
    assign total_wide   = (TB + CW)'(total_reg);
    assign prio_out     = {1'b0, top_reg} + (LB + 1)'(1);
    assign prio_wide    = (LB + PW + 1)'(prio_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
            total_reg <= total_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg   <= ST_READ;
                        status_reg  <= status_c;
                        removed_reg <= pop_ok ? head_task_reg : '0;
                        any_reg     <= new_any;
                        top_reg     <= new_top;
                        fwd_reg     <= push_ok && (new_top == lv) && (count_reg[lv] == '0);
                        fwd_id_reg  <= id_in;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_IDLE;
                    head_task_reg <= head_word;
                    out_valid_reg <= 1'b1;
                    out_reg.status          <= status_reg;
                    out_reg.head_valid      <= any_reg;
                    out_reg.head_task_id    <= any_reg ? head_wide[IDW-1:0] : '0;
                    out_reg.head_priority   <= any_reg ? prio_wide[PW-1:0] : '0;
                    out_reg.removed_task_id <= removed_wide[IDW-1:0];
                    out_reg.total_count     <= total_wide[CW-1:0];
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.head_valid      = out_reg.head_valid;
    assign rsp.head_task_id    = out_reg.head_task_id;
    assign rsp.head_priority   = out_reg.head_priority;
    assign rsp.removed_task_id = out_reg.removed_task_id;
    assign rsp.total_count     = out_reg.total_count;

endmodule

// ===== hw/rtl/multilevel_priority_queue.sv =====
// top level of the multilevel priority queue: pointer control plus task memory
//
//   channel | dir | words carried
//   --------+-----+---------------------------------------------------------
//   req     | in  | func, task_id, priority_req
//   rsp     | out | status, head_valid, head_task_id, head_priority,
//           |     | removed_task_id, total_count
//
// each request runs in two states: the accept cycle updates the level pointers and
// writes the memory, the next cycle gets the new head word from the registered
// memory read and loads the response register.
// reset clears pointers and counts at once; the task memory is not cleared.
// a held response stalls the next request until it is taken.
module multilevel_priority_queue #(
    parameter int LEVELS  = mpq_pkg::LEVELS_DEFAULT,
    parameter int DEPTH   = mpq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = mpq_pkg::ID_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    mpq_in_if.sink    req,
    mpq_out_if.source rsp
);

    localparam int WORDS     = LEVELS * DEPTH;
    localparam int ADDR_BITS = $clog2(WORDS);

    logic                 mem_wr_en;
    logic [ADDR_BITS-1:0] mem_wr_addr;
    logic [ID_BITS-1:0]   mem_wr_data;
    logic [ADDR_BITS-1:0] mem_rd_addr;
    logic [ID_BITS-1:0]   mem_rd_data;

    mpq_ctrl #(
        .LEVELS    (LEVELS),
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    mpq_store #(
        .WORDS     (WORDS),
        .WORD_BITS (ID_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== sim/tb_multilevel_priority_queue.sv =====
// testbench for multilevel_priority_queue: random push/pop traffic checked against a queue model
module tb_multilevel_priority_queue;

    localparam int LEVELS  = mpq_pkg::LEVELS_DEFAULT;
    localparam int DEPTH   = mpq_pkg::DEPTH_DEFAULT;
    localparam int ID_BITS = mpq_pkg::ID_BITS_DEFAULT;
    localparam int IDW     = mpq_pkg::ID_FIELD_BITS;
    localparam int PW      = mpq_pkg::PRIO_BITS;
    localparam int CW      = mpq_pkg::COUNT_FIELD_BITS;

    typedef struct packed {
        logic           func;
        logic [IDW-1:0] id;
        logic [PW-1:0]  prio;
    } req_word_t;

    logic clk;
    logic rst_n;

    mpq_in_if  req ();
    mpq_out_if rsp ();

    multilevel_priority_queue #(
        .LEVELS  (LEVELS),
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // queue model: one ring buffer per level
    logic [IDW-1:0] lvl_store [LEVELS][DEPTH];
    int unsigned    lvl_head  [LEVELS];
    int unsigned    lvl_tail  [LEVELS];
    int unsigned    lvl_fill  [LEVELS];

    req_word_t         request_backlog [$];
    mpq_pkg::result_t  due_responses [$];

    int n_sent;
    int n_taken;
    int n_checked;
    int mismatches;
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_phase;
    int rx_tick;
    int n_ok;
    int n_full;
    int n_bad_prio;
    int n_empty_pop;
    int peak_total;

    function automatic int highest_busy_level();
        int l;
        for (l = LEVELS - 1; l >= 0; l--)
            if (lvl_fill[l] != 0)
                return l;
        return -1;
    endfunction

    function automatic mpq_pkg::result_t predict_queue(input req_word_t w);
        mpq_pkg::result_t r;
        int lv;
        int top;
        int total;
        r = '0;
        r.status = mpq_pkg::STATUS_OK;
        total = 0;
        if (w.func == mpq_pkg::FUNC_PUSH)
        begin
            if (w.prio == 0 || w.prio > LEVELS)
            begin
                r.status = mpq_pkg::STATUS_BAD_PRIO;
            end
            else
            begin
                lv = int'(w.prio) - 1;
                if (lvl_fill[lv] >= DEPTH)
                begin
                    r.status = mpq_pkg::STATUS_FULL;
                end
                else
                begin
                    lvl_store[lv][lvl_tail[lv]] = w.id;
                    lvl_tail[lv] = (lvl_tail[lv] + 1) % DEPTH;
                    lvl_fill[lv]++;
                end
            end
        end
        else
        begin
            top = highest_busy_level();
            if (top < 0)
            begin
                r.status = mpq_pkg::STATUS_EMPTY_POP;
            end
            else
            begin
                r.removed_task_id = lvl_store[top][lvl_head[top]];
                lvl_head[top] = (lvl_head[top] + 1) % DEPTH;
                lvl_fill[top]--;
            end
        end
        for (lv = 0; lv < LEVELS; lv++)
            total += lvl_fill[lv];
        top = highest_busy_level();
        if (top >= 0)
        begin
            r.head_valid    = 1'b1;
            r.head_task_id  = lvl_store[top][lvl_head[top]];
            r.head_priority = PW'(top + 1);
        end
        r.total_count = CW'(total);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_word(input logic f, input logic [15:0] id, input logic [3:0] p);
        req_word_t w;
        w.func = f;
        w.id   = id;
        w.prio = p;
        request_backlog.push_back(w);
    endtask

    function automatic logic [3:0] bad_prio();
        if ($urandom_range(0, 2) == 0)
            return 4'd0;
        return 4'($urandom_range(LEVELS + 1, 15));
    endfunction

    // mostly well-formed push/pop sequences, some floods and fills, a little noise
    task automatic gen_traffic(input int n);
        int added;
        int kind;
        int len;
        int lv;
        int k;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                len = $urandom_range(4, 24);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 55)
                        add_word(mpq_pkg::FUNC_PUSH, 16'($urandom_range(0, 65535)),
                                 ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, LEVELS))
                                                             : bad_prio());
                    else
                        add_word(mpq_pkg::FUNC_POP, 16'($urandom_range(0, 65535)),
                                 4'($urandom_range(0, 15)));
                end
            end
            else if (kind < 55)
            begin
                // run one level into its full limit
                lv = $urandom_range(1, LEVELS);
                len = DEPTH + $urandom_range(0, 3);
                for (k = 0; k < len; k++)
                    add_word(mpq_pkg::FUNC_PUSH, 16'($urandom_range(0, 65535)), 4'(lv));
            end
            else if (kind < 70)
            begin
                len = $urandom_range(4, 40);
                for (k = 0; k < len; k++)
                    add_word(mpq_pkg::FUNC_POP, 16'($urandom_range(0, 65535)),
                             4'($urandom_range(0, 15)));
            end
            else if (kind < 85)
            begin
                len = $urandom_range(6, 30);
                for (k = 0; k < len; k++)
                    add_word(k[0] ? mpq_pkg::FUNC_POP : mpq_pkg::FUNC_PUSH,
                             16'($urandom_range(0, 65535)),
                             ($urandom_range(0, 1) != 0) ? 4'(LEVELS) : 4'd1);
            end
            else if (kind < 89)
            begin
                // fill every level toward total capacity
                len = LEVELS * DEPTH + $urandom_range(4, 20);
                for (k = 0; k < len; k++)
                    add_word(mpq_pkg::FUNC_PUSH, 16'($urandom_range(0, 65535)),
                             4'($urandom_range(1, LEVELS)));
            end
            else
            begin
                len = $urandom_range(2, 10);
                for (k = 0; k < len; k++)
                    add_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                             4'($urandom_range(0, 15)));
            end
            added += len;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (req.valid && n_sent != n_taken)
        begin
            // word still waiting for ready
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            req.valid <= 1'b0;
        end
        else if (request_backlog.size() > 0)
        begin
            req.valid        <= 1'b1;
            req.func         <= request_backlog[0].func;
            req.task_id      <= request_backlog[0].id;
            req.priority_req <= request_backlog[0].prio;
            n_sent++;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
        begin
            req.valid <= 1'b0;
        end
    end

    // response ready pattern
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rx_tick++;
            if (rx_phase <= 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_phase = $urandom_range(50, 300);
            end
            else
            begin
                rx_phase--;
            end
            case (rx_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(0, 1));
                2: rsp.ready <= ($urandom_range(0, 7) != 0);
                default: rsp.ready <= (rx_tick % 32 == 0);
            endcase
        end
    end

    // monitor: check responses, then record newly accepted requests
    always @(posedge clk)
    begin
        mpq_pkg::result_t want;
        req_word_t        w;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response word with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("head_valid", 16'(want.head_valid), 16'(rsp.head_valid));
                    check_field("head_task_id", want.head_task_id, rsp.head_task_id);
                    check_field("head_priority", 16'(want.head_priority),
                                16'(rsp.head_priority));
                    check_field("removed_task_id", want.removed_task_id,
                                rsp.removed_task_id);
                    check_field("total_count", 16'(want.total_count), 16'(rsp.total_count));
                    n_checked++;
                end
            end
            if (req.valid && req.ready)
            begin
                w.func = req.func;
                w.id   = req.task_id;
                w.prio = req.priority_req;
                want = predict_queue(w);
                case (want.status)
                    mpq_pkg::STATUS_OK:       n_ok++;
                    mpq_pkg::STATUS_FULL:     n_full++;
                    mpq_pkg::STATUS_BAD_PRIO: n_bad_prio++;
                    default:                  n_empty_pop++;
                endcase
                if (int'(want.total_count) > peak_total)
                    peak_total = int'(want.total_count);
                due_responses.push_back(want);
                void'(request_backlog.pop_front());
                n_taken++;
            end
        end
    end

    initial
    begin
        int l;
        req.valid        = 1'b0;
        req.func         = mpq_pkg::FUNC_PUSH;
        req.task_id      = '0;
        req.priority_req = '0;
        rsp.ready        = 1'b0;
        rst_n            = 1'b0;
        n_sent = 0;
        n_taken = 0;
        n_checked = 0;
        mismatches = 0;
        burst_left = 1;
        gap_left = 0;
        rx_mode = 0;
        rx_phase = 0;
        rx_tick = 0;
        n_ok = 0;
        n_full = 0;
        n_bad_prio = 0;
        n_empty_pop = 0;
        peak_total = 0;
        for (l = 0; l < LEVELS; l++)
        begin
            lvl_head[l] = 0;
            lvl_tail[l] = 0;
            lvl_fill[l] = 0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, out-of-range priorities, extreme ids and levels
        add_word(mpq_pkg::FUNC_POP,  16'h0000, 4'd0);
        add_word(mpq_pkg::FUNC_PUSH, 16'hffff, 4'd0);
        add_word(mpq_pkg::FUNC_PUSH, 16'h0000, 4'd15);
        add_word(mpq_pkg::FUNC_PUSH, 16'h1234, 4'(LEVELS + 1));
        add_word(mpq_pkg::FUNC_PUSH, 16'h0000, 4'd1);
        add_word(mpq_pkg::FUNC_PUSH, 16'hffff, 4'(LEVELS));
        add_word(mpq_pkg::FUNC_PUSH, 16'h8001, 4'(LEVELS));
        add_word(mpq_pkg::FUNC_PUSH, 16'h7ffe, 4'd4);
        add_word(mpq_pkg::FUNC_POP,  16'hffff, 4'd15);
        add_word(mpq_pkg::FUNC_POP,  16'h0000, 4'd0);
        add_word(mpq_pkg::FUNC_POP,  16'h5a5a, 4'd8);
        add_word(mpq_pkg::FUNC_POP,  16'ha5a5, 4'd1);
        add_word(mpq_pkg::FUNC_POP,  16'h0000, 4'd0);
        gen_traffic(1000);

        // sender holds off until the block has answered everything
        while (request_backlog.size() != 0 || due_responses.size() != 0)
            @(posedge clk);
        gen_traffic(1000);
        while (request_backlog.size() != 0 || due_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d requests, %0d responses checked; peak occupancy %0d of %0d",
                 n_taken, n_checked, peak_total, LEVELS * DEPTH);
        $display("accepted %0d, full-level drops %0d, bad priority %0d, empty pops %0d",
                 n_ok, n_full, n_bad_prio, n_empty_pop);
        if (mismatches == 0 && due_responses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $error("run did not finish in time: %0d responses outstanding",
               due_responses.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
